// File: hw/rtl/page_framebuffer_fill_refresh_macros.svh
// assertion helpers, all sampled on clk and held off while arst_n is low
`ifndef PAGE_FRAMEBUFFER_FILL_REFRESH_MACROS_SVH
`define PAGE_FRAMEBUFFER_FILL_REFRESH_MACROS_SVH

// same-cycle implication
`define PFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the cycle after the antecedent
`define PFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pfb_pkg.sv
package pfb_pkg;

	// request codes
	localparam logic [2:0] REQ_DRAW    = 3'd0;
	localparam logic [2:0] REQ_FILL    = 3'd1;
	localparam logic [2:0] REQ_CLEAR   = 3'd2;
	localparam logic [2:0] REQ_REFRESH = 3'd3;
	localparam logic [2:0] REQ_TICK    = 3'd4;

	// panel command bytes
	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

	// start commands into the sweep unit
	typedef struct packed {
		logic fill;
		logic clear;
	} walk_cmd_t;

	// what the sweep unit does this cycle
	typedef struct packed {
		logic       busy;
		logic       rd;
		logic       wr_zero;
		logic [7:0] mask;
	} walk_step_t;

endpackage

// File: hw/rtl/pfb_if.sv
interface pfb_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [6:0] x_start;
	logic [5:0] y_start;
	logic [6:0] x_end;
	logic [5:0] y_end;
	logic       pixel_on;

	modport source (output valid, req_type, x_start, y_start, x_end, y_end, pixel_on,
		input ready);
	modport sink (input valid, req_type, x_start, y_start, x_end, y_end, pixel_on,
		output ready);
endinterface

interface pfb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       refresh_done;

	modport source (output valid, out_byte, is_data, refresh_done, input ready);
	modport sink (input valid, out_byte, is_data, refresh_done, output ready);
endinterface

// File: hw/rtl/pfb_ram.sv
module pfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/pfb_walk.sv
module pfb_walk #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pfb_pkg::walk_cmd_t               cmd,
	input  logic [6:0]                       x_start,
	input  logic [5:0]                       y_start,
	input  logic [6:0]                       x_end,
	input  logic [5:0]                       y_end,
	output pfb_pkg::walk_step_t              step,
	output logic [$clog2(COLUMNS*PAGES)-1:0] addr
);

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int ROWS  = 8 * PAGES;

	typedef enum logic [1:0] {W_IDLE, W_CLEAR, W_FILL} mode_t;

	mode_t          mode_q;
	logic [AW-1:0]  clr_q;
	logic [CW-1:0]  col_q;
	logic [CW-1:0]  col_hi_q;
	logic [PW-1:0]  page_q;
	logic [PW-1:0]  page_lo_q;
	logic [PW-1:0]  page_hi_q;
	logic [2:0]     ys3_q;
	logic [2:0]     ye3_q;

	logic [8:0]     xe_c;
	logic [8:0]     ye_c;
	logic           rect_ok;
	logic [PW-1:0]  pg_top;
	logic [PW-1:0]  pg_bot;
	logic [2:0]     lo_off;
	logic [2:0]     hi_off;
	logic [AW-1:0]  fill_addr;

	// clip the rectangle to the panel
	always_comb begin
		xe_c = ({2'b00, x_end} > 9'(COLUMNS - 1)) ? 9'(COLUMNS - 1) : {2'b00, x_end};
		ye_c = ({3'b000, y_end} > 9'(ROWS - 1)) ? 9'(ROWS - 1) : {3'b000, y_end};
		rect_ok = (x_start <= x_end) && (y_start <= y_end)
			&& ({2'b00, x_start} < 9'(COLUMNS)) && ({3'b000, y_start} < 9'(ROWS));
		// larger y sits in a lower page
		pg_top = PW'(PAGES - 1) - PW'(y_start[5:3]);
		pg_bot = PW'(PAGES - 1) - PW'(ye_c[5:3]);
	end

	always_comb begin
		lo_off    = (page_q == page_hi_q) ? ys3_q : 3'd0;
		hi_off    = (page_q == page_lo_q) ? ye3_q : 3'd7;
		fill_addr = AW'(AW'(col_q) * AW'(PAGES)) + AW'(page_q);

		step.busy    = (mode_q != W_IDLE);
		step.rd      = (mode_q == W_FILL);
		step.wr_zero = (mode_q == W_CLEAR);
		step.mask    = (8'hFF >> lo_off) & (8'hFF << (3'd7 - hi_off));
		addr         = (mode_q == W_CLEAR) ? clr_q : fill_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// the store is swept to zero straight out of reset
			mode_q    <= W_CLEAR;
			clr_q     <= '0;
			col_q     <= '0;
			col_hi_q  <= '0;
			page_q    <= '0;
			page_lo_q <= '0;
			page_hi_q <= '0;
			ys3_q     <= '0;
			ye3_q     <= '0;
		end else begin
			case (mode_q)
				W_IDLE: begin
					if (cmd.clear) begin
						mode_q <= W_CLEAR;
						clr_q  <= '0;
					end else if (cmd.fill && rect_ok) begin
						mode_q    <= W_FILL;
						col_q     <= CW'(x_start);
						col_hi_q  <= CW'(xe_c);
						page_q    <= pg_bot;
						page_lo_q <= pg_bot;
						page_hi_q <= pg_top;
						ys3_q     <= y_start[2:0];
						ye3_q     <= ye_c[2:0];
					end
				end
				W_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						mode_q <= W_IDLE;
					end
				end
				W_FILL: begin
					if (page_q == page_hi_q) begin
						page_q <= page_lo_q;
						if (col_q == col_hi_q) begin
							mode_q <= W_IDLE;
						end else begin
							col_q <= col_q + CW'(1);
						end
					end else begin
						page_q <= page_q + PW'(1);
					end
				end
				default: begin
					mode_q <= W_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/page_framebuffer_fill_refresh.sv
// channel  dir  carries                                         transfer
// req      in   req_type x_start y_start x_end y_end pixel_on   valid & ready
// rsp      out  out_byte is_data refresh_done                   valid & ready
//
// after reset the store is swept to zero, with req.ready low until the sweep ends
// draw reads a store byte and writes it back; a tick waits while the result register is full
// fill walks the columns*pages of the clipped rectangle, one store byte per cycle
// clear writes zero to all COLUMNS*PAGES bytes through the single write port of the store
// a finished result stays in the output register while the next request is taken
module page_framebuffer_fill_refresh #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	pfb_req_if.sink   req,
	pfb_rsp_if.source rsp
);

	`include "page_framebuffer_fill_refresh_macros.svh"

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int POSW  = $clog2(COLUMNS + 3);
	localparam int ROWS  = 8 * PAGES;

	typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_TICK} state_t;

	state_t              state_q;
	logic                busy_q;
	logic [PW-1:0]       page_q;
	logic [POSW-1:0]     pos_q;
	logic                on_q;
	logic                wr_s1;
	logic [AW-1:0]       addr_s1;
	logic [7:0]          mask_s1;
	logic                on_s1;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_data_q;
	logic                out_done_q;

	pfb_pkg::walk_cmd_t  walk_cmd;
	pfb_pkg::walk_step_t step;
	logic [AW-1:0]       walk_addr;

	logic                acc;
	logic                draw_ok;
	logic                tick_go;
	logic                start_ref;
	logic [CW-1:0]       pt_col;
	logic [PW-1:0]       pt_page;
	logic [AW-1:0]       pt_addr;
	logic [7:0]          pt_mask;
	logic                re;
	logic [AW-1:0]       raddr;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [7:0]          wdata;
	logic [7:0]          rdata;
	logic                out_free;
	logic                load_out;
	logic                pos_last;
	logic                page_last;
	logic [7:0]          tick_byte;
	logic                tick_data;

	assign req.ready = (state_q == S_IDLE) && !step.busy;
	assign acc       = req.valid && req.ready;

	always_comb begin
		walk_cmd.fill  = 1'b0;
		walk_cmd.clear = 1'b0;
		draw_ok        = 1'b0;
		tick_go        = 1'b0;
		start_ref      = 1'b0;
		case (req.req_type)
			pfb_pkg::REQ_DRAW: begin
				draw_ok = acc && ({2'b00, req.x_start} < 9'(COLUMNS))
					&& ({3'b000, req.y_start} < 9'(ROWS));
			end
			pfb_pkg::REQ_FILL: begin
				walk_cmd.fill = acc;
				start_ref     = acc;
			end
			pfb_pkg::REQ_CLEAR: begin
				walk_cmd.clear = acc;
				start_ref      = acc;
			end
			pfb_pkg::REQ_REFRESH: begin
				start_ref = acc;
			end
			pfb_pkg::REQ_TICK: begin
				tick_go = acc && busy_q;
			end
			default: begin
			end
		endcase
	end

	// one address path for a single pixel and for the byte a tick sends
	always_comb begin
		if (req.req_type == pfb_pkg::REQ_TICK) begin
			pt_col  = CW'(pos_q - POSW'(3));
			pt_page = page_q;
		end else begin
			pt_col  = CW'(req.x_start);
			pt_page = PW'(PAGES - 1) - PW'(req.y_start[5:3]);
		end
		pt_addr = AW'(AW'(pt_col) * AW'(PAGES)) + AW'(pt_page);
		pt_mask = 8'h80 >> req.y_start[2:0];
	end

	always_comb begin
		re    = draw_ok || tick_go || step.rd;
		raddr = step.rd ? walk_addr : pt_addr;
		we    = wr_s1 || step.wr_zero;
		waddr = step.wr_zero ? walk_addr : addr_s1;
		if (step.wr_zero) begin
			wdata = 8'h00;
		end else if (on_s1) begin
			wdata = rdata | mask_s1;
		end else begin
			wdata = rdata & ~mask_s1;
		end
	end

	always_comb begin
		out_free  = !out_valid_q || rsp.ready;
		load_out  = (state_q == S_TICK) && out_free;
		pos_last  = (pos_q == POSW'(COLUMNS + 2));
		page_last = (page_q == PW'(PAGES - 1));
		tick_data = 1'b0;
		case (pos_q)
			POSW'(0): tick_byte = pfb_pkg::CMD_PAGE_BASE + 8'(page_q);
			POSW'(1): tick_byte = pfb_pkg::CMD_COL_LOW;
			POSW'(2): tick_byte = pfb_pkg::CMD_COL_HIGH;
			default: begin
				tick_byte = rdata;
				tick_data = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= 1'b0;
			page_q      <= '0;
			pos_q       <= '0;
			on_q        <= 1'b0;
			wr_s1       <= 1'b0;
			addr_s1     <= '0;
			mask_s1     <= '0;
			on_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_data_q  <= 1'b0;
			out_done_q  <= 1'b0;
		end else begin
			wr_s1 <= 1'b0;
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						on_q <= req.pixel_on;
						if (start_ref) begin
							busy_q <= 1'b1;
							page_q <= '0;
							pos_q  <= '0;
						end
						if (draw_ok) begin
							wr_s1   <= 1'b1;
							addr_s1 <= pt_addr;
							mask_s1 <= pt_mask;
							on_s1   <= req.pixel_on;
						end
						if (tick_go) begin
							state_q <= S_TICK;
						end else if (draw_ok || walk_cmd.fill || walk_cmd.clear) begin
							state_q <= S_SWEEP;
						end
					end
				end
				S_SWEEP: begin
					// read in this cycle, modify and write back in the next
					if (step.rd) begin
						wr_s1   <= 1'b1;
						addr_s1 <= walk_addr;
						mask_s1 <= step.mask;
						on_s1   <= on_q;
					end
					if (!step.busy) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (load_out) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						out_byte_q  <= tick_byte;
						out_data_q  <= tick_data;
						out_done_q  <= pos_last && page_last;
						if (pos_last) begin
							pos_q <= '0;
							if (page_last) begin
								page_q <= '0;
								busy_q <= 1'b0;
							end else begin
								page_q <= page_q + PW'(1);
							end
						end else begin
							pos_q <= pos_q + POSW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_byte     = out_byte_q;
	assign rsp.is_data      = out_data_q;
	assign rsp.refresh_done = out_done_q;

	pfb_walk #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (walk_cmd),
		.x_start(req.x_start),
		.y_start(req.y_start),
		.x_end  (req.x_end),
		.y_end  (req.y_end),
		.step   (step),
		.addr   (walk_addr)
	);

	pfb_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	`PFB_ASSERT_NOW(a_no_write_clash, wr_s1, !step.wr_zero, "pixel write during clear sweep")
	`PFB_ASSERT_NOW(a_no_pending_write, acc, !wr_s1, "request taken with a write pending")
	`PFB_ASSERT_NOW(a_done_on_data, out_valid_q && out_done_q, out_data_q,
		"refresh end flagged on a command byte")
	`PFB_ASSERT_NEXT(a_done_ends_refresh, load_out && pos_last && page_last, !busy_q,
		"refresh still running after its final byte")

endmodule
